// File: rtl/core/imu_ti_pkg.sv
package imu_ti_pkg;

    localparam int STAMP_W = 32;
    localparam int TICK_W  = 32;
    localparam int PROD_W  = STAMP_W + TICK_W;
    localparam int AXES    = 3;

    localparam logic [TICK_W-1:0] TICK_RESET = 32'd4294967;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_RESET  = 2'd1,
        OP_ZERO   = 2'd2,
        OP_OFFSET = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROD,
        S_SUM,
        S_HI,
        S_LO,
        S_DELTA,
        S_ADD,
        S_LOAD
    } t_state;

    typedef struct packed {
        logic       take;
        logic       prod;
        logic       sum;
        logic       hi;
        logic       lo;
        logic       delta;
        logic       add;
        logic       load;
        logic [1:0] axis;
        logic       kind;
    } t_cmd;

    typedef struct packed {
        logic primed;
    } t_status;

endpackage

// File: rtl/core/imu_ti_ifs.sv
interface imu_ti_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    op;
    logic signed [SAMPLE_BITS-1:0] gyro_x;
    logic signed [SAMPLE_BITS-1:0] gyro_y;
    logic signed [SAMPLE_BITS-1:0] gyro_z;
    logic signed [SAMPLE_BITS-1:0] accel_x;
    logic signed [SAMPLE_BITS-1:0] accel_y;
    logic signed [SAMPLE_BITS-1:0] accel_z;
    logic [31:0]                   stamp;

    modport source (
        output valid, op, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z, stamp,
        input  ready
    );
    modport sink (
        input  valid, op, gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z, stamp,
        output ready
    );
endinterface

interface imu_ti_out_if #(
    parameter int SAMPLE_BITS = 16,
    parameter int ACC_BITS    = 48
);
    logic                          valid;
    logic                          ready;
    logic signed [ACC_BITS-1:0]    incl_x;
    logic signed [ACC_BITS-1:0]    incl_y;
    logic signed [ACC_BITS-1:0]    incl_z;
    logic signed [ACC_BITS-1:0]    vel_x;
    logic signed [ACC_BITS-1:0]    vel_y;
    logic signed [ACC_BITS-1:0]    vel_z;
    logic signed [SAMPLE_BITS+1:0] rate_x;
    logic signed [SAMPLE_BITS+1:0] rate_y;
    logic signed [SAMPLE_BITS+1:0] rate_z;
    logic signed [SAMPLE_BITS-1:0] acc_now_x;
    logic signed [SAMPLE_BITS-1:0] acc_now_y;
    logic signed [SAMPLE_BITS-1:0] acc_now_z;

    modport source (
        output valid, incl_x, incl_y, incl_z, vel_x, vel_y, vel_z,
               rate_x, rate_y, rate_z, acc_now_x, acc_now_y, acc_now_z,
        input  ready
    );
    modport sink (
        input  valid, incl_x, incl_y, incl_z, vel_x, vel_y, vel_z,
               rate_x, rate_y, rate_z, acc_now_x, acc_now_y, acc_now_z,
        output ready
    );
endinterface

// File: rtl/core/imu_trapezoid_integrator.sv
// Three-axis gyro and accelerometer trapezoid integrator. Each transfer on the input
// channel carries one command; each produces exactly one result, the state after it.
// Commands other than an integrating sample, and the first sample after reset, go from
// the transfer through S_LOAD to the output register. An integrating sample forms the
// tick-length product, then takes each of the six accumulators in turn through sum, hi,
// lo, delta and add on one shared multiplier for both partial products, then loads the
// output register once it is free. The next command is taken once the result is loaded,
// so a waiting result does not block it. tick_length is set via i_cfg_we/i_cfg_data.
module imu_trapezoid_integrator
    import imu_ti_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int ACC_BITS    = 48
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [TICK_W-1:0] i_cfg_data,
    imu_ti_in_if.sink         i_in,
    imu_ti_out_if.source      o_out
);

    t_cmd    w_cmd;
    t_status w_status;

    logic signed [SAMPLE_BITS-1:0] w_gyro  [AXES];
    logic signed [SAMPLE_BITS-1:0] w_accel [AXES];
    logic signed [ACC_BITS-1:0]    w_incl  [AXES];
    logic signed [ACC_BITS-1:0]    w_vel   [AXES];
    logic signed [SAMPLE_BITS+1:0] w_rate  [AXES];
    logic signed [SAMPLE_BITS-1:0] w_acc   [AXES];

    assign w_gyro[0]  = i_in.gyro_x;
    assign w_gyro[1]  = i_in.gyro_y;
    assign w_gyro[2]  = i_in.gyro_z;
    assign w_accel[0] = i_in.accel_x;
    assign w_accel[1] = i_in.accel_y;
    assign w_accel[2] = i_in.accel_z;

    imu_ti_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_op     (i_in.op),
        .i_out_ready (o_out.ready),
        .i_status    (w_status),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_cmd       (w_cmd)
    );

    imu_ti_dp #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .ACC_BITS    (ACC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .i_op       (i_in.op),
        .i_gyro     (w_gyro),
        .i_accel    (w_accel),
        .i_stamp    (i_in.stamp),
        .o_status   (w_status),
        .o_incl     (w_incl),
        .o_vel      (w_vel),
        .o_rate     (w_rate),
        .o_acc      (w_acc)
    );

    assign o_out.incl_x    = w_incl[0];
    assign o_out.incl_y    = w_incl[1];
    assign o_out.incl_z    = w_incl[2];
    assign o_out.vel_x     = w_vel[0];
    assign o_out.vel_y     = w_vel[1];
    assign o_out.vel_z     = w_vel[2];
    assign o_out.rate_x    = w_rate[0];
    assign o_out.rate_y    = w_rate[1];
    assign o_out.rate_z    = w_rate[2];
    assign o_out.acc_now_x = w_acc[0];
    assign o_out.acc_now_y = w_acc[1];
    assign o_out.acc_now_z = w_acc[2];

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input transfer while an item is in flight");

    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(w_cmd.load))
        else $error("result valid without a load");

    a_phase_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.take, w_cmd.prod, w_cmd.sum, w_cmd.hi,
                  w_cmd.lo, w_cmd.delta, w_cmd.add, w_cmd.load}))
        else $error("more than one datapath command at once");

endmodule

// File: rtl/core/imu_ti_ctrl.sv
module imu_ti_ctrl
    import imu_ti_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_in_op,
    input  logic       i_out_ready,
    input  t_status    i_status,
    output logic       o_in_ready,
    output logic       o_out_valid,
    output t_cmd       o_cmd
);

    t_state     r_state, n_state;
    logic [1:0] r_axis, n_axis;
    logic       r_kind, n_kind;
    logic       r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_axis      <= '0;
            r_kind      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_axis      <= n_axis;
            r_kind      <= n_kind;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_axis     = r_axis;
        n_kind     = r_kind;
        o_cmd      = '0;
        o_cmd.axis = r_axis;
        o_cmd.kind = r_kind;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.take = 1'b1;
                    if (t_op'(i_in_op) == OP_SAMPLE && i_status.primed) begin
                        n_state = S_PROD;
                    end else begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_PROD: begin
                o_cmd.prod = 1'b1;
                n_axis     = '0;
                n_kind     = 1'b0;
                n_state    = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_HI;
            end
            S_HI: begin
                o_cmd.hi = 1'b1;
                n_state  = S_LO;
            end
            S_LO: begin
                o_cmd.lo = 1'b1;
                n_state  = S_DELTA;
            end
            S_DELTA: begin
                o_cmd.delta = 1'b1;
                n_state     = S_ADD;
            end
            S_ADD: begin
                o_cmd.add = 1'b1;
                if (r_axis == 2'd2) begin
                    n_axis = '0;
                    if (r_kind) begin
                        n_state = S_LOAD;
                    end else begin
                        n_kind  = 1'b1;
                        n_state = S_SUM;
                    end
                end else begin
                    n_axis  = r_axis + 2'd1;
                    n_state = S_SUM;
                end
            end
            S_LOAD: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// File: rtl/core/imu_ti_dp.sv
module imu_ti_dp
    import imu_ti_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int ACC_BITS    = 48
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [TICK_W-1:0]             i_cfg_data,
    input  t_cmd                          i_cmd,
    input  logic [1:0]                    i_op,
    input  logic signed [SAMPLE_BITS-1:0] i_gyro  [AXES],
    input  logic signed [SAMPLE_BITS-1:0] i_accel [AXES],
    input  logic [STAMP_W-1:0]            i_stamp,
    output t_status                       o_status,
    output logic signed [ACC_BITS-1:0]    o_incl  [AXES],
    output logic signed [ACC_BITS-1:0]    o_vel   [AXES],
    output logic signed [SAMPLE_BITS+1:0] o_rate  [AXES],
    output logic signed [SAMPLE_BITS-1:0] o_acc   [AXES]
);

    localparam int SB    = SAMPLE_BITS;
    localparam int S_W   = SB + 2;
    localparam int M_W   = SB + 1;
    localparam int A_W   = M_W + TICK_W;
    localparam int MAG_W = ((ACC_BITS - 1 > SB + 17) ? ACC_BITS - 1 : SB + 17) + 1;
    localparam logic [ACC_BITS-2:0] LIM = '1;
    localparam logic signed [ACC_BITS-1:0] ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
    localparam logic signed [ACC_BITS-1:0] ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

    logic signed [SB-1:0]       r_gyro_last  [AXES];
    logic signed [SB-1:0]       r_gyro_prev  [AXES];
    logic signed [SB-1:0]       r_accel_last [AXES];
    logic signed [SB-1:0]       r_accel_prev [AXES];
    logic signed [SB:0]         r_bias       [AXES];
    logic signed [ACC_BITS-1:0] r_incl       [AXES];
    logic signed [ACC_BITS-1:0] r_vel        [AXES];
    logic [STAMP_W-1:0]         r_stamp_last;
    logic [STAMP_W-1:0]         r_stamp_prev;
    logic [1:0]                 r_count;
    logic [TICK_W-1:0]          r_tick;

    logic [PROD_W-1:0]          r_prod;
    logic [M_W-1:0]             r_mag;
    logic                       r_neg;
    logic [A_W-1:0]             r_hi;
    logic [A_W-1:0]             r_lo;
    logic signed [ACC_BITS-1:0] r_delta;

    logic signed [ACC_BITS-1:0] r_out_incl [AXES];
    logic signed [ACC_BITS-1:0] r_out_vel  [AXES];
    logic signed [S_W-1:0]      r_out_rate [AXES];
    logic signed [SB-1:0]       r_out_acc  [AXES];

    logic [STAMP_W-1:0]         w_dtick;
    logic signed [S_W-1:0]      w_sum;
    logic [TICK_W-1:0]          w_mul_b;
    logic [A_W-1:0]             w_mult;
    logic                       w_big;
    logic [MAG_W-1:0]           w_mag_sum;
    logic [ACC_BITS-2:0]        w_mag;
    logic signed [ACC_BITS-1:0] w_acc_cur;
    logic signed [ACC_BITS:0]   w_tot;
    logic signed [ACC_BITS-1:0] w_acc_new;
    logic                       w_full;

    assign w_full          = (r_count == 2'd2);
    assign o_status.primed = (r_count != 2'd0);

    assign w_dtick = r_stamp_last - r_stamp_prev;

    always_comb begin
        if (i_cmd.kind) begin
            w_sum = S_W'(r_gyro_last[i_cmd.axis]) + S_W'(r_gyro_prev[i_cmd.axis])
                  - S_W'(r_bias[i_cmd.axis]);
        end else begin
            w_sum = S_W'(r_accel_last[i_cmd.axis]) + S_W'(r_accel_prev[i_cmd.axis]);
        end
    end

    assign w_mul_b = i_cmd.hi ? r_prod[PROD_W-1:TICK_W] : r_prod[TICK_W-1:0];
    assign w_mult  = A_W'(r_mag) * A_W'(w_mul_b);

    assign w_big     = (r_hi >> (ACC_BITS - 16)) != '0;
    assign w_mag_sum = (MAG_W'(r_hi) << 15) + MAG_W'(r_lo >> 17);
    assign w_mag     = (w_big || (w_mag_sum > MAG_W'(LIM))) ? LIM
                                                           : w_mag_sum[ACC_BITS-2:0];

    assign w_acc_cur = i_cmd.kind ? r_incl[i_cmd.axis] : r_vel[i_cmd.axis];
    assign w_tot     = {w_acc_cur[ACC_BITS-1], w_acc_cur} + {r_delta[ACC_BITS-1], r_delta};

    always_comb begin
        if (w_tot[ACC_BITS] != w_tot[ACC_BITS-1]) begin
            w_acc_new = w_tot[ACC_BITS] ? ACC_MIN : ACC_MAX;
        end else begin
            w_acc_new = w_tot[ACC_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= TICK_RESET;
        end else if (i_cfg_we) begin
            r_tick <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXES; i++) begin
                r_gyro_last[i]  <= '0;
                r_gyro_prev[i]  <= '0;
                r_accel_last[i] <= '0;
                r_accel_prev[i] <= '0;
                r_bias[i]       <= '0;
                r_incl[i]       <= '0;
                r_vel[i]        <= '0;
            end
            r_stamp_last <= '0;
            r_stamp_prev <= '0;
            r_count      <= '0;
        end else if (i_cmd.take) begin
            unique case (t_op'(i_op))
                OP_SAMPLE: begin
                    for (int i = 0; i < AXES; i++) begin
                        r_gyro_prev[i]  <= r_gyro_last[i];
                        r_accel_prev[i] <= r_accel_last[i];
                        r_gyro_last[i]  <= i_gyro[i];
                        r_accel_last[i] <= i_accel[i];
                        if (r_count == 2'd0) begin
                            r_incl[i] <= '0;
                            r_vel[i]  <= '0;
                        end
                    end
                    r_stamp_prev <= r_stamp_last;
                    r_stamp_last <= i_stamp;
                    if (!w_full) begin
                        r_count <= r_count + 2'd1;
                    end
                end
                OP_RESET: begin
                    for (int i = 0; i < AXES; i++) begin
                        if (w_full) begin
                            r_bias[i] <= (SB+1)'(r_gyro_last[i]) + (SB+1)'(r_gyro_prev[i]);
                        end
                        r_incl[i] <= '0;
                    end
                end
                OP_ZERO: begin
                    for (int i = 0; i < AXES; i++) begin
                        r_incl[i] <= '0;
                    end
                end
                OP_OFFSET: begin
                    if (w_full) begin
                        for (int i = 0; i < AXES; i++) begin
                            r_bias[i] <= (SB+1)'(r_gyro_last[i]) + (SB+1)'(r_gyro_prev[i]);
                        end
                    end
                end
                default: ;
            endcase
        end else if (i_cmd.add) begin
            if (i_cmd.kind) begin
                r_incl[i_cmd.axis] <= w_acc_new;
            end else begin
                r_vel[i_cmd.axis] <= w_acc_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prod) begin
            r_prod <= PROD_W'(w_dtick) * PROD_W'(r_tick);
        end
        if (i_cmd.sum) begin
            r_neg <= w_sum[S_W-1];
            r_mag <= M_W'(w_sum[S_W-1] ? -w_sum : w_sum);
        end
        if (i_cmd.hi) begin
            r_hi <= w_mult;
        end
        if (i_cmd.lo) begin
            r_lo <= w_mult;
        end
        if (i_cmd.delta) begin
            r_delta <= r_neg ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
        end
        if (i_cmd.load) begin
            for (int i = 0; i < AXES; i++) begin
                r_out_incl[i] <= r_incl[i];
                r_out_vel[i]  <= r_vel[i];
                r_out_rate[i] <= (S_W'(r_gyro_last[i]) <<< 1) - S_W'(r_bias[i]);
                r_out_acc[i]  <= r_accel_last[i];
            end
        end
    end

    assign o_incl = r_out_incl;
    assign o_vel  = r_out_vel;
    assign o_rate = r_out_rate;
    assign o_acc  = r_out_acc;

endmodule

// File: test/imu_trapezoid_integrator_tb.sv
module imu_trapezoid_integrator_tb;
    import imu_ti_pkg::*;

    localparam int SAMPLE_BITS = 16;
    localparam int ACC_BITS    = 48;
    localparam int CYCLE_LIMIT = 1_000_000;

    localparam longint          ACC_MAX   = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint          ACC_MIN   = -ACC_MAX - 1;
    localparam longint unsigned ACC_MAX_U = 64'h0000_7FFF_FFFF_FFFF;

    typedef struct packed {
        t_op                             op;
        logic [2:0][SAMPLE_BITS-1:0]     gyro;
        logic [2:0][SAMPLE_BITS-1:0]     accel;
        logic [STAMP_W-1:0]              stamp;
    } t_imu_cmd;

    typedef struct packed {
        logic [2:0][ACC_BITS-1:0]        incl;
        logic [2:0][ACC_BITS-1:0]        vel;
        logic [2:0][SAMPLE_BITS+1:0]     rate;
        logic [2:0][SAMPLE_BITS-1:0]     acc_now;
    } t_imu_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              cfg_we;
    logic [TICK_W-1:0] cfg_data;

    imu_ti_in_if  #(.SAMPLE_BITS(SAMPLE_BITS)) in_if ();
    imu_ti_out_if #(.SAMPLE_BITS(SAMPLE_BITS), .ACC_BITS(ACC_BITS)) out_if ();

    imu_trapezoid_integrator #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .ACC_BITS   (ACC_BITS)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_data(cfg_data),
        .i_in      (in_if.sink),
        .o_out     (out_if.source)
    );

    // Integrator state as the block should hold it
    bit [TICK_W-1:0]  tick_len = TICK_RESET;
    int               gyro_now [3];
    int               gyro_old [3];
    int               accel_now [3];
    int               accel_old [3];
    bit [STAMP_W-1:0] stamp_now;
    bit [STAMP_W-1:0] stamp_old;
    int               samples_held;
    int               bias2 [3];
    longint           incl_acc [3];
    longint           vel_acc [3];

    t_imu_result      pending_states [$];
    int               fail_count;
    int               cycle_count;
    int               send_idle_pct;
    int               recv_idle_pct;
    bit [STAMP_W-1:0] stamp_cursor;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint trapezoid_delta(longint s, longint unsigned p);
        longint unsigned m;
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned mag;
        m  = (s < 0) ? -s : s;
        hi = m * (p >> 32);
        lo = m * (p & 64'hFFFF_FFFF);
        if (hi > (ACC_MAX_U >> 15)) begin
            mag = ACC_MAX_U;
        end else begin
            mag = (hi << 15) + (lo >> 17);
            if (mag > ACC_MAX_U) begin
                mag = ACC_MAX_U;
            end
        end
        return (s < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic longint saturate_sum(longint acc, longint d);
        if (d > 0 && acc > ACC_MAX - d) begin
            return ACC_MAX;
        end
        if (d < 0 && acc < ACC_MIN - d) begin
            return ACC_MIN;
        end
        return acc + d;
    endfunction

    function automatic void capture_bias();
        if (samples_held >= 2) begin
            for (int i = 0; i < 3; i++) begin
                bias2[i] = gyro_now[i] + gyro_old[i];
            end
        end
    endfunction

    function automatic t_imu_result integrate_command(t_imu_cmd c);
        t_imu_result     r;
        bit [31:0]       dtick;
        longint unsigned p;
        longint          asum;
        longint          gsum;
        int              rate;
        case (c.op)
            OP_SAMPLE: begin
                for (int i = 0; i < 3; i++) begin
                    gyro_old[i]  = gyro_now[i];
                    accel_old[i] = accel_now[i];
                    gyro_now[i]  = int'($signed(c.gyro[i]));
                    accel_now[i] = int'($signed(c.accel[i]));
                end
                stamp_old = stamp_now;
                stamp_now = c.stamp;
                if (samples_held < 2) begin
                    samples_held++;
                end
                if (samples_held < 2) begin
                    for (int i = 0; i < 3; i++) begin
                        incl_acc[i] = 0;
                        vel_acc[i]  = 0;
                    end
                end else begin
                    dtick = stamp_now - stamp_old;
                    p     = 64'(dtick) * 64'(tick_len);
                    for (int i = 0; i < 3; i++) begin
                        asum        = longint'(accel_now[i] + accel_old[i]);
                        gsum        = longint'(gyro_now[i] + gyro_old[i] - bias2[i]);
                        vel_acc[i]  = saturate_sum(vel_acc[i], trapezoid_delta(asum, p));
                        incl_acc[i] = saturate_sum(incl_acc[i], trapezoid_delta(gsum, p));
                    end
                end
            end
            OP_RESET: begin
                capture_bias();
                for (int i = 0; i < 3; i++) begin
                    incl_acc[i] = 0;
                end
            end
            OP_ZERO: begin
                for (int i = 0; i < 3; i++) begin
                    incl_acc[i] = 0;
                end
            end
            default: begin
                capture_bias();
            end
        endcase
        for (int i = 0; i < 3; i++) begin
            rate         = 2 * gyro_now[i] - bias2[i];
            r.incl[i]    = incl_acc[i][ACC_BITS-1:0];
            r.vel[i]     = vel_acc[i][ACC_BITS-1:0];
            r.rate[i]    = rate[SAMPLE_BITS+1:0];
            r.acc_now[i] = accel_now[i][SAMPLE_BITS-1:0];
        end
        return r;
    endfunction

    function automatic t_imu_cmd sample_cmd(logic [15:0] gx, logic [15:0] gy, logic [15:0] gz,
                                            logic [15:0] ax, logic [15:0] ay, logic [15:0] az,
                                            logic [31:0] st);
        t_imu_cmd c;
        c.op    = OP_SAMPLE;
        c.gyro  = {gz, gy, gx};
        c.accel = {az, ay, ax};
        c.stamp = st;
        return c;
    endfunction

    // Control commands carry random sample fields, which must be ignored
    function automatic t_imu_cmd control_cmd(t_op op);
        t_imu_cmd c;
        c       = sample_cmd(16'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom), 16'($urandom), $urandom);
        c.op    = op;
        return c;
    endfunction

    function automatic logic [15:0] pick_count();
        if ($urandom_range(4) == 0) begin
            return 16'($urandom_range(0, 64) - 32);
        end
        return 16'($urandom);
    endfunction

    function automatic logic [31:0] pick_tick_step();
        case ($urandom_range(9))
            0:       return 32'd0;
            1:       return $urandom;
            default: return $urandom_range(1, 20000);
        endcase
    endfunction

    task automatic check_field(string what, logic [47:0] want, logic [47:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s expected %h got %h", $time, what, want, got);
        end
    endtask

    // Result channel: random back-pressure, check each transfer
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_imu_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (pending_states.size() == 0) begin
                fail_count++;
                $display("%0t: result with none expected, incl_x %h vel_x %h",
                         $time, out_if.incl_x, out_if.vel_x);
            end else begin
                want = pending_states.pop_front();
                check_field("incl_x", want.incl[0], $unsigned(out_if.incl_x));
                check_field("incl_y", want.incl[1], $unsigned(out_if.incl_y));
                check_field("incl_z", want.incl[2], $unsigned(out_if.incl_z));
                check_field("vel_x", want.vel[0], $unsigned(out_if.vel_x));
                check_field("vel_y", want.vel[1], $unsigned(out_if.vel_y));
                check_field("vel_z", want.vel[2], $unsigned(out_if.vel_z));
                check_field("rate_x", 48'(want.rate[0]), 48'($unsigned(out_if.rate_x)));
                check_field("rate_y", 48'(want.rate[1]), 48'($unsigned(out_if.rate_y)));
                check_field("rate_z", 48'(want.rate[2]), 48'($unsigned(out_if.rate_z)));
                check_field("acc_now_x", 48'(want.acc_now[0]),
                            48'($unsigned(out_if.acc_now_x)));
                check_field("acc_now_y", 48'(want.acc_now[1]),
                            48'($unsigned(out_if.acc_now_y)));
                check_field("acc_now_z", 48'(want.acc_now[2]),
                            48'($unsigned(out_if.acc_now_z)));
            end
        end
    end

    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("imu_trapezoid_integrator test failed");
        $finish;
    end

    task automatic send_command(input t_imu_cmd c);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.op      = c.op;
        in_if.gyro_x  = c.gyro[0];
        in_if.gyro_y  = c.gyro[1];
        in_if.gyro_z  = c.gyro[2];
        in_if.accel_x = c.accel[0];
        in_if.accel_y = c.accel[1];
        in_if.accel_z = c.accel[2];
        in_if.stamp   = c.stamp;
        in_if.valid   = 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
        pending_states.push_back(integrate_command(c));
    endtask

    task automatic wait_until_drained();
        @(negedge i_clk);
        in_if.valid = 1'b0;
        while (pending_states.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_tick(logic [TICK_W-1:0] value);
        wait_until_drained();
        @(negedge i_clk);
        cfg_we   = 1'b1;
        cfg_data = value;
        @(negedge i_clk);
        cfg_we   = 1'b0;
        tick_len = value;
    endtask

    task automatic test_startup_commands();
        send_command(control_cmd(OP_OFFSET));
        send_command(control_cmd(OP_RESET));
        send_command(control_cmd(OP_ZERO));
        send_command(sample_cmd(16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                                16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'hFFFF_FFF0));
        send_command(control_cmd(OP_OFFSET));
        send_command(control_cmd(OP_RESET));
    endtask

    task automatic test_sample_extremes();
        // stamp wraps past zero, then repeats for a zero step
        send_command(sample_cmd(16'sh8000, 16'sh8000, 16'sh8000,
                                16'sh8000, 16'sh8000, 16'sh8000, 32'h0000_0010));
        send_command(sample_cmd(16'sh7FFF, 16'sh8000, 16'sh0000,
                                16'sh0000, 16'sh7FFF, 16'sh8000, 32'h0000_0010));
        send_command(sample_cmd(16'sh0001, 16'shFFFF, 16'sh7FFF,
                                16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'h8000_0010));
        send_command(control_cmd(OP_OFFSET));
        send_command(sample_cmd(16'sh0100, 16'shFF00, 16'sh8000,
                                16'sh8000, 16'sh0000, 16'sh7FFF, 32'h8000_1010));
        send_command(control_cmd(OP_ZERO));
        send_command(sample_cmd(16'sh7FFF, 16'sh7FFF, 16'sh8000,
                                16'sh1234, 16'shEDCB, 16'sh0000, 32'h8100_0000));
        send_command(control_cmd(OP_RESET));
        send_command(sample_cmd(16'sh0000, 16'sh0000, 16'sh0000,
                                16'sh0000, 16'sh0000, 16'sh0000, 32'h8100_0400));
        stamp_cursor = 32'h8100_0400;
    endtask

    task automatic test_tick_extremes();
        write_tick(32'hFFFF_FFFF);
        // a near full-period step drives the accumulators into saturation both ways
        repeat (2) begin
            stamp_cursor += 32'hFFFF_FFFF;
            send_command(sample_cmd(16'sh7FFF, 16'sh8000, 16'sh7FFF,
                                    16'sh8000, 16'sh8000, 16'sh8000, stamp_cursor));
        end
        repeat (3) begin
            stamp_cursor += 32'hFFFF_FFFF;
            send_command(sample_cmd(16'sh8000, 16'sh7FFF, 16'sh8000,
                                    16'sh7FFF, 16'sh7FFF, 16'sh7FFF, stamp_cursor));
        end
        write_tick(32'h0000_0000);
        repeat (2) begin
            stamp_cursor += $urandom;
            send_command(sample_cmd(pick_count(), pick_count(), pick_count(),
                                    pick_count(), pick_count(), pick_count(), stamp_cursor));
        end
    endtask

    task automatic run_random_block(int items);
        t_imu_cmd c;
        for (int n = 0; n < items; n++) begin
            if ($urandom_range(99) < 85) begin
                stamp_cursor += pick_tick_step();
                c = sample_cmd(pick_count(), pick_count(), pick_count(),
                               pick_count(), pick_count(), pick_count(), stamp_cursor);
            end else begin
                c = control_cmd(t_op'($urandom_range(1, 3)));
            end
            send_command(c);
        end
    endtask

    task automatic test_random_slow_sink();
        send_idle_pct = 10;
        recv_idle_pct = 74;
        write_tick($urandom >> $urandom_range(0, 31));
        run_random_block(300);
        write_tick($urandom >> $urandom_range(0, 31));
        run_random_block(300);
    endtask

    task automatic test_random_slow_source();
        send_idle_pct = 74;
        recv_idle_pct = 10;
        write_tick($urandom);
        run_random_block(300);
        write_tick($urandom_range(1, 100000));
        run_random_block(300);
    endtask

    task automatic test_random_full_rate();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_tick(TICK_RESET);
        run_random_block(600);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_data      = '0;
        in_if.valid   = 1'b0;
        in_if.op      = OP_SAMPLE;
        in_if.gyro_x  = '0;
        in_if.gyro_y  = '0;
        in_if.gyro_z  = '0;
        in_if.accel_x = '0;
        in_if.accel_y = '0;
        in_if.accel_z = '0;
        in_if.stamp   = '0;
        send_idle_pct = 10;
        recv_idle_pct = 74;
        fail_count    = 0;
        stamp_cursor  = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_startup_commands();
        test_sample_extremes();
        test_tick_extremes();
        test_random_slow_sink();
        test_random_slow_source();
        test_random_full_rate();

        wait_until_drained();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("imu_trapezoid_integrator test passed");
        end else begin
            $display("imu_trapezoid_integrator test failed");
        end
        $finish;
    end

endmodule
